>>> hdl/mex_pkg.sv
// Shared constants, types and state encoding for the modular exponentiation block.
`default_nettype none

package mex_pkg;

  localparam int unsigned BASE_W = 31;
  localparam int unsigned EXP_W  = 31;
  localparam int unsigned RES_W  = 30;

  // Prime modulus 1000000007 (between 2^29 and 2^30)
  localparam logic [RES_W-1:0] PRIME_MOD = 30'd1000000007;
  // Exponent used for the Fermat inverse
  localparam logic [EXP_W-1:0] INV_EXP = 31'(PRIME_MOD) - 31'd2;
  // Barrett factor floor(2^60 / P)
  localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'(PRIME_MOD));

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SQUARE,
    ST_MULT,
    ST_WAIT,
    ST_DONE
  } mex_state_e;

  typedef struct packed {
    logic load;       // capture a new input transaction
    logic issue_sq;   // push sq * sq into the multiplier
    logic issue_mul;  // push acc * sq into the multiplier
    logic shift_exp;  // drop the exponent bit just handled
    logic publish;    // move acc into the output register
  } mex_cmd_t;

  typedef struct packed {
    logic exp_zero;
    logic exp_lsb;
    logic busy;       // multiplier pipeline holds work
    logic out_free;   // output register can take a result this cycle
  } mex_sts_t;

endpackage

`default_nettype wire

>>> hdl/mex_mulmod.sv
// Pipelined modular multiplier, Barrett reduction modulo 1000000007.
`default_nettype none

module mex_mulmod (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_tag_i,
  input  logic [mex_pkg::RES_W-1:0] in_a_i,
  input  logic [mex_pkg::RES_W-1:0] in_b_i,
  output logic                      out_valid_o,
  output logic                      out_tag_o,
  output logic [mex_pkg::RES_W-1:0] out_res_o,
  output logic                      busy_o
);

  logic [4:0] v_q, v_d;
  logic [4:0] t_q, t_d;

  logic [mex_pkg::RES_W-1:0] a0_q, b0_q;
  logic [59:0]               prod1_q, prod1_d;
  logic [30:0]               q2_q, q2_d;
  logic [31:0]               x2_q, x3_q;
  logic [31:0]               qp3_q, qp3_d;
  logic [mex_pkg::RES_W-1:0] res4_q, res4_d;

  logic [61:0] mu_prod;
  logic [31:0] rem, rem1, rem2;
  logic [31:0] prime32;

  assign v_d = {v_q[3:0], in_valid_i};
  assign t_d = {t_q[3:0], in_tag_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
      t_q <= '0;
    end else begin
      v_q <= v_d;
      t_q <= t_d;
    end
  end

  always_comb begin
    prime32 = 32'(mex_pkg::PRIME_MOD);
    prod1_d = 60'(a0_q) * 60'(b0_q);
    mu_prod = 62'(prod1_q[59:29]) * 62'(mex_pkg::BARRETT_MU);
    q2_d    = mu_prod[61:31];
    // only the low word matters: the true remainder is below 3P < 2^32
    qp3_d   = 32'(q2_q) * prime32;
    rem     = x3_q - qp3_q;
    rem1    = rem - prime32;
    rem2    = rem - (prime32 << 1);
    if (rem >= (prime32 << 1)) begin
      res4_d = rem2[mex_pkg::RES_W-1:0];
    end else if (rem >= prime32) begin
      res4_d = rem1[mex_pkg::RES_W-1:0];
    end else begin
      res4_d = rem[mex_pkg::RES_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    a0_q    <= in_a_i;
    b0_q    <= in_b_i;
    prod1_q <= prod1_d;
    q2_q    <= q2_d;
    x2_q    <= prod1_q[31:0];
    qp3_q   <= qp3_d;
    x3_q    <= x2_q;
    res4_q  <= res4_d;
  end

  assign out_valid_o = v_q[4];
  assign out_tag_o   = t_q[4];
  assign out_res_o   = res4_q;
  assign busy_o      = |v_q;

endmodule

`default_nettype wire

>>> hdl/mex_datapath.sv
// Datapath: exponent, accumulator and square registers, multiplier, output register.
`default_nettype none

module mex_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mex_pkg::mex_cmd_t          cmd_i,
  output mex_pkg::mex_sts_t          sts_o,
  input  logic [mex_pkg::BASE_W-1:0] base_i,
  input  logic [mex_pkg::EXP_W-1:0]  exp_i,
  input  logic                       mode_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [mex_pkg::RES_W-1:0]  out_res_o
);

  localparam logic TAG_SQ  = 1'b0;
  localparam logic TAG_MUL = 1'b1;

  logic [mex_pkg::EXP_W-1:0] exp_q, exp_d;
  logic [mex_pkg::RES_W-1:0] acc_q, acc_d;
  logic [mex_pkg::RES_W-1:0] sq_q, sq_d;
  logic [mex_pkg::RES_W-1:0] out_data_q, out_data_d;
  logic                      out_valid_q, out_valid_d;

  logic [mex_pkg::BASE_W-1:0] base_red;
  logic                       mm_valid, mm_tag;
  logic [mex_pkg::RES_W-1:0]  mm_res;
  logic                       mm_busy;
  logic                       out_free;

  mex_mulmod u_mulmod (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.issue_sq | cmd_i.issue_mul),
    .in_tag_i    (cmd_i.issue_mul ? TAG_MUL : TAG_SQ),
    .in_a_i      (cmd_i.issue_mul ? acc_q : sq_q),
    .in_b_i      (sq_q),
    .out_valid_o (mm_valid),
    .out_tag_o   (mm_tag),
    .out_res_o   (mm_res),
    .busy_o      (mm_busy)
  );

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    // base < 2^31 < 3P, so at most 2P comes off
    if (base_i >= {mex_pkg::PRIME_MOD, 1'b0}) begin
      base_red = base_i - {mex_pkg::PRIME_MOD, 1'b0};
    end else if (base_i >= 31'(mex_pkg::PRIME_MOD)) begin
      base_red = base_i - 31'(mex_pkg::PRIME_MOD);
    end else begin
      base_red = base_i;
    end
    exp_d      = exp_q;
    acc_d      = acc_q;
    sq_d       = sq_q;
    out_data_d = out_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.load) begin
      exp_d = mode_i ? mex_pkg::INV_EXP : exp_i;
      acc_d = 30'd1;
      sq_d  = base_red[mex_pkg::RES_W-1:0];
    end
    if (cmd_i.shift_exp) begin
      exp_d = exp_q >> 1;
    end
    if (mm_valid) begin
      if (mm_tag == TAG_MUL) begin
        acc_d = mm_res;
      end else begin
        sq_d = mm_res;
      end
    end
    if (cmd_i.publish) begin
      out_data_d  = acc_q;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q      <= exp_d;
    acc_q      <= acc_d;
    sq_q       <= sq_d;
    out_data_q <= out_data_d;
  end

  assign sts_o.exp_zero = (exp_q == '0);
  assign sts_o.exp_lsb  = exp_q[0];
  assign sts_o.busy     = mm_busy;
  assign sts_o.out_free = out_free;

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_data_q;

endmodule

`default_nettype wire

>>> hdl/mex_ctrl.sv
// Controller: sequences square and multiply per exponent bit, one transaction at a time.
`default_nettype none

module mex_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mex_pkg::mex_sts_t sts_i,
  output mex_pkg::mex_cmd_t cmd_o
);

  mex_pkg::mex_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mex_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      mex_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = mex_pkg::ST_CHECK;
        end
      end
      mex_pkg::ST_CHECK: begin
        state_d = sts_i.exp_zero ? mex_pkg::ST_DONE : mex_pkg::ST_SQUARE;
      end
      mex_pkg::ST_SQUARE: begin
        cmd_o.issue_sq = 1'b1;
        state_d        = mex_pkg::ST_MULT;
      end
      mex_pkg::ST_MULT: begin
        // multiply uses the square value from before this bit's squaring
        cmd_o.issue_mul = sts_i.exp_lsb;
        cmd_o.shift_exp = 1'b1;
        state_d         = mex_pkg::ST_WAIT;
      end
      mex_pkg::ST_WAIT: begin
        if (!sts_i.busy) begin
          state_d = mex_pkg::ST_CHECK;
        end
      end
      mex_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = mex_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mex_pkg::ST_IDLE;
      end
    endcase
  end

  a_issue_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue_sq |-> !sts_i.busy)
    else $error("square issued while multiplier busy");

  a_mul_follows_sq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue_mul |-> $past(cmd_o.issue_sq))
    else $error("multiply not paired with square");

  a_publish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |-> sts_i.out_free)
    else $error("result published into occupied output register");

  a_check_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mex_pkg::ST_CHECK) |-> !sts_i.busy)
    else $error("exponent checked before multiplier drained");

endmodule

`default_nettype wire

>>> hdl/modular_exponentiation.sv
// Top level: modular exponentiation modulo 1000000007 by square-and-multiply.
//
//  channel  dir  handshake                       payload
//  s_axis   in   s_axis_tvalid_i/s_axis_tready_o tdata: base, exponent; tuser: mode
//  m_axis   out  m_axis_tvalid_o/m_axis_tready_i tdata: residue
//
// One transaction at a time. Each exponent bit steps through check, square, multiply
// through the shared Barrett multiplier, then drain; the multiply is issued only when
// the bit is set. A finished result waits in the output register while the next input
// is taken; the controller waits for output space only while that register is full.
// Reset clears the controller, valid flags and multiplier tags only; no clearing pass.
`default_nettype none

module modular_exponentiation (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [30:0] base_value, [61:31] exponent_value, zero pad
  input  logic        s_axis_tuser_i,   // [0] mode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // [29:0] residue, zero pad
);

  mex_pkg::mex_cmd_t         cmd;
  mex_pkg::mex_sts_t         sts;
  logic [mex_pkg::RES_W-1:0] res;

  mex_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mex_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .base_i      (s_axis_tdata_i[30:0]),
    .exp_i       (s_axis_tdata_i[61:31]),
    .mode_i      (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (res)
  );

  assign m_axis_tdata_o = {2'b00, res};

endmodule

`default_nettype wire

>>> dv/tb_modular_exponentiation.sv
// Testbench for the modular exponentiation block: random and directed streams checked against a predictor.
`timescale 1ns / 100ps

module tb_modular_exponentiation;

  localparam longint unsigned MODULUS      = 64'd1000000007;
  localparam logic [30:0]     INV_EXPONENT = 31'd1000000005;  // Fermat: P - 2
  localparam logic [30:0]     FIELD_MAX    = 31'h7FFF_FFFF;
  localparam logic            MODE_POWER   = 1'b0;
  localparam logic            MODE_INVERSE = 1'b1;
  localparam int              HOLD_CYCLES  = 2000;
  localparam int              ITEMS_PER_PHASE = 400;

  typedef struct packed {
    logic [30:0] base;
    logic [30:0] exponent;
    logic        mode;
  } mex_item_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // [30:0] base_value, [61:31] exponent_value, zero pad
  logic        s_axis_tuser = 1'b0; // [0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [29:0] residue, zero pad

  mex_item_t   pending_q[$];
  logic [29:0] residue_q[$];
  mex_item_t   offered;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_off = 1'b0;
  int unsigned fail_cnt = 0;
  event        hold_start;

  modular_exponentiation u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  // Square-and-multiply over the exponent bits, 64-bit products.
  function automatic logic [29:0] power_residue(mex_item_t it);
    longint unsigned acc;
    longint unsigned sq;
    logic [30:0]     k;
    k   = (it.mode == MODE_INVERSE) ? INV_EXPONENT : it.exponent;
    acc = 64'd1;
    sq  = 64'(it.base) % MODULUS;
    while (k != 0) begin
      if (k[0]) acc = (acc * sq) % MODULUS;
      sq = (sq * sq) % MODULUS;
      k  = k >> 1;
    end
    return acc[29:0];
  endfunction

  function automatic mex_item_t random_item();
    mex_item_t   it;
    int unsigned sel;
    int unsigned len;
    logic [31:0] bits;
    sel = $urandom_range(0, 99);
    if (sel < 20) begin
      case ($urandom_range(0, 5))
        0: it.base = '0;
        1: it.base = 31'(MODULUS);
        2: it.base = 31'(MODULUS - 1);
        3: it.base = 31'd1;
        4: it.base = FIELD_MAX;
        default: it.base = 31'(MODULUS * 2);
      endcase
    end else begin
      it.base = 31'($urandom);
    end
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      it.exponent = 31'($urandom);
    end else if (sel < 80) begin
      // leading one at a random position, so run length varies
      len  = $urandom_range(0, 31);
      bits = (len == 0) ? 32'd0 :
             (($urandom & ((32'd1 << len) - 1)) | (32'd1 << (len - 1)));
      it.exponent = bits[30:0];
    end else begin
      it.exponent = 31'($urandom_range(0, 16));
    end
    it.mode = ($urandom_range(0, 99) < 15) ? MODE_INVERSE : MODE_POWER;
    return it;
  endfunction

  task automatic queue_item(logic [30:0] b, logic [30:0] e, logic m);
    mex_item_t it;
    it.base     = b;
    it.exponent = e;
    it.mode     = m;
    pending_q.push_back(it);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || s_axis_tvalid || residue_q.size() != 0);
  endtask

  // Input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) residue_q.push_back(power_residue(offered));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          offered = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {2'b00, offered.exponent, offered.base};
          s_axis_tuser  <= offered.mode;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor
  always @(posedge clk_i or negedge rst_ni) begin
    logic [29:0] want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (residue_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected result: expected none, actual residue %0d",
                   $time, m_axis_tdata[29:0]);
        end else begin
          want = residue_q.pop_front();
          if (m_axis_tdata[29:0] !== want) begin
            fail_cnt++;
            $display("%0t: residue mismatch: expected %0d, actual %0d",
                     $time, want, m_axis_tdata[29:0]);
          end
        end
      end
      m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off so the block backs up into its input
  initial begin
    @(hold_start);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #30ms;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed corners
    queue_item('0, '0, MODE_POWER);
    queue_item(31'(MODULUS), '0, MODE_POWER);
    queue_item('0, 31'd5, MODE_POWER);
    queue_item('0, '0, MODE_INVERSE);
    queue_item(31'(MODULUS), 31'd123, MODE_INVERSE);
    queue_item(31'(MODULUS * 2), 31'd7, MODE_POWER);
    queue_item(31'd1, FIELD_MAX, MODE_POWER);
    queue_item(FIELD_MAX, FIELD_MAX, MODE_POWER);
    queue_item(FIELD_MAX, '0, MODE_INVERSE);
    queue_item(31'(MODULUS - 1), 31'd2, MODE_POWER);
    queue_item(31'(MODULUS - 1), FIELD_MAX, MODE_POWER);
    queue_item(31'd2, 31'd29, MODE_POWER);
    queue_item(31'd2, 31'd30, MODE_POWER);
    queue_item(31'd3, 31'(MODULUS - 1), MODE_POWER);
    queue_item(31'd12345, 31'd1, MODE_POWER);
    queue_item(31'd2, '0, MODE_INVERSE);
    queue_item(31'(MODULUS + 1), FIELD_MAX, MODE_INVERSE);
    queue_item(31'h5555_5555, 31'h2AAA_AAAA, MODE_POWER);
    queue_item(31'h2AAA_AAAA, 31'h5555_5555, MODE_POWER);
    queue_item(31'(MODULUS - 1), '0, MODE_INVERSE);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct <= 62; recv_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_stall_pct <= 62; end
        default: begin send_idle_pct <= 27; recv_stall_pct <= 27; end
      endcase
      if (ph == 0) -> hold_start;
      repeat (ITEMS_PER_PHASE) pending_q.push_back(random_item());
      wait_drained();
    end

    repeat (300) @(posedge clk_i);
    if (residue_q.size() != 0) fail_cnt++;
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
